[rtl/rswf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rswf_pkg
// Shared types and constants for the redundant state write filter.
// ----------------------------------------------------------------------------
package rswf_pkg;

  // Write kinds, as carried on operation / out_kind
  localparam logic KIND_RENDER  = 1'b0;
  localparam logic KIND_SAMPLER = 1'b1;

  // Sampler numbers at or above REMAP_FROM are shown downstream shifted up
  localparam logic [4:0] REMAP_FROM = 5'd16;
  localparam logic [8:0] REMAP_ADD  = 9'd241;

  localparam int VALUE_W = 32;

  // One shadow table entry
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
  } entry_t;

endpackage

[rtl/rswf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rswf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rswf_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/redundant_state_write_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// redundant_state_write_filter
// Drops state writes that would not change the shadowed device state.
// ----------------------------------------------------------------------------
// Takes one state write per cycle while in_stall is low, returns one result
// beat per write, registered in the stage-1 lookup registers and then in the
// output register. A render write and a sampler write each look up their
// shadow table (one RAM each, registered read), compare in the next cycle and
// write back on the way into the output register; a one-entry bypass per table
// covers a write to the same entry on the very next beat. After reset the block
// sweeps both RAMs to clear their valid marks, one entry per cycle, over
// max(RENDER_STATES, SAMPLERS * SAMPLER_STATES) addresses (320 at the default
// sizes); in_stall stays high during that sweep. Out-of-range indexes give
// index_error with forwarded low and leave the tables and counters alone.
// The forward counters wrap at 2^32 and each result beat carries both
// counters as they stand after that write.
// ----------------------------------------------------------------------------
module redundant_state_write_filter #(
  parameter int RENDER_STATES  = 256,
  parameter int SAMPLERS       = 20,
  parameter int SAMPLER_STATES = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [4:0]  sampler_index,
  input  logic [7:0]  state_index,
  input  logic [31:0] new_value,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        forwarded,
  output logic        out_kind,
  output logic [8:0]  out_sampler,
  output logic [7:0]  out_state,
  output logic [31:0] out_value,
  output logic [31:0] render_forwards,
  output logic [31:0] sampler_forwards,
  output logic        index_error
);
  import rswf_pkg::*;

  localparam int SAMPLER_ENTRIES = SAMPLERS * SAMPLER_STATES;
  localparam int RA_W      = $clog2(RENDER_STATES);
  localparam int SA_W      = $clog2(SAMPLER_ENTRIES);
  localparam int CLR_DEPTH = (RENDER_STATES > SAMPLER_ENTRIES) ? RENDER_STATES
                                                               : SAMPLER_ENTRIES;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  // --------------------------------------------------------------------------
  // Handshake and clearing sweep
  // --------------------------------------------------------------------------
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;
  logic             s1_valid;
  logic             s1_advance;
  logic             accept;

  assign s1_advance = !out_valid || !out_stall;
  assign in_stall   = clearing || (s1_valid && !s1_advance);
  assign accept     = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Input decode: range check, table addresses, remapped sampler number
  // --------------------------------------------------------------------------
  logic            in_err;
  logic [RA_W-1:0] in_raddr;
  logic [SA_W-1:0] in_saddr;
  logic [8:0]      in_api;

  always_comb begin
    if (operation == KIND_RENDER) begin
      in_err = int'(state_index) >= RENDER_STATES;
    end else begin
      in_err = (int'(sampler_index) >= SAMPLERS) ||
               (int'(state_index) >= SAMPLER_STATES);
    end
    in_raddr = RA_W'(state_index);
    in_saddr = SA_W'(int'(sampler_index) * SAMPLER_STATES + int'(state_index));
    if (operation == KIND_RENDER) begin
      in_api = '0;
    end else if (sampler_index >= REMAP_FROM) begin
      in_api = 9'(sampler_index) + REMAP_ADD;
    end else begin
      in_api = 9'(sampler_index);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: lookup registers
  // --------------------------------------------------------------------------
  logic            s1_kind;
  logic            s1_err;
  logic [8:0]      s1_api;
  logic [7:0]      s1_state;
  logic [31:0]     s1_value;
  logic [RA_W-1:0] s1_raddr;
  logic [SA_W-1:0] s1_saddr;

  // last write to each table, valid once that table has taken a write
  logic            byp_r_valid;
  logic [RA_W-1:0] byp_r_addr;
  logic [31:0]     byp_r_value;
  logic            byp_s_valid;
  logic [SA_W-1:0] byp_s_addr;
  logic [31:0]     byp_s_value;

  entry_t r_rdata;
  entry_t s_rdata;
  entry_t r_entry;
  entry_t s_entry;
  entry_t cur_entry;
  logic   fwd;
  logic   commit;
  logic   r_commit;
  logic   s_commit;

  logic [31:0] render_count;
  logic [31:0] sampler_count;
  logic [31:0] render_count_next;
  logic [31:0] sampler_count_next;

  always_comb begin
    // the RAM read may predate the previous beat's write: take the bypass
    if (byp_r_valid && byp_r_addr == s1_raddr) begin
      r_entry = '{valid: 1'b1, value: byp_r_value};
    end else begin
      r_entry = r_rdata;
    end
    if (byp_s_valid && byp_s_addr == s1_saddr) begin
      s_entry = '{valid: 1'b1, value: byp_s_value};
    end else begin
      s_entry = s_rdata;
    end
    cur_entry = (s1_kind == KIND_SAMPLER) ? s_entry : r_entry;
    fwd       = !s1_err && !(cur_entry.valid && cur_entry.value == s1_value);
    commit    = s1_valid && s1_advance && fwd;
    r_commit  = commit && (s1_kind == KIND_RENDER);
    s_commit  = commit && (s1_kind == KIND_SAMPLER);
    render_count_next  = render_count + 32'(r_commit);
    sampler_count_next = sampler_count + 32'(s_commit);
  end

  // --------------------------------------------------------------------------
  // Shadow tables; the write port is shared by the clearing sweep
  // --------------------------------------------------------------------------
  logic            r_we;
  logic [RA_W-1:0] r_waddr;
  entry_t          r_wdata;
  logic            s_we;
  logic [SA_W-1:0] s_waddr;
  entry_t          s_wdata;

  always_comb begin
    if (clearing) begin
      r_we    = int'(clr_cnt) < RENDER_STATES;
      r_waddr = clr_cnt[RA_W-1:0];
      r_wdata = '0;
      s_we    = int'(clr_cnt) < SAMPLER_ENTRIES;
      s_waddr = clr_cnt[SA_W-1:0];
      s_wdata = '0;
    end else begin
      r_we    = r_commit;
      r_waddr = s1_raddr;
      r_wdata = '{valid: 1'b1, value: s1_value};
      s_we    = s_commit;
      s_waddr = s1_saddr;
      s_wdata = '{valid: 1'b1, value: s1_value};
    end
  end

  rswf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (RENDER_STATES)
  ) u_render_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .re    (accept),
    .raddr (in_raddr),
    .rdata (r_rdata)
  );

  rswf_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SAMPLER_ENTRIES)
  ) u_sampler_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (accept),
    .raddr (in_saddr),
    .rdata (s_rdata)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing      <= 1'b1;
      clr_cnt       <= '0;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      render_count  <= '0;
      sampler_count <= '0;
      byp_r_valid   <= 1'b0;
      byp_s_valid   <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_cnt == CLR_W'(CLR_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
        clr_cnt <= clr_cnt + CLR_W'(1);
      end
      if (!s1_valid || s1_advance) begin
        s1_valid <= accept;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
      render_count  <= render_count_next;
      sampler_count <= sampler_count_next;
      if (r_commit) begin
        byp_r_valid <= 1'b1;
      end
      if (s_commit) begin
        byp_s_valid <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= operation;
      s1_err   <= in_err;
      s1_api   <= in_api;
      s1_state <= state_index;
      s1_value <= new_value;
      s1_raddr <= in_raddr;
      s1_saddr <= in_saddr;
    end
    if (r_commit) begin
      byp_r_addr  <= s1_raddr;
      byp_r_value <= s1_value;
    end
    if (s_commit) begin
      byp_s_addr  <= s1_saddr;
      byp_s_value <= s1_value;
    end
    if (s1_valid && s1_advance) begin
      forwarded        <= fwd;
      out_kind         <= s1_kind;
      out_sampler      <= s1_api;
      out_state        <= s1_state;
      out_value        <= s1_value;
      render_forwards  <= render_count_next;
      sampler_forwards <= sampler_count_next;
      index_error      <= s1_err;
    end
  end

endmodule

[rtl/rswf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rswf_checker
// Port-level checks for the redundant state write filter, bound to the top.
// ----------------------------------------------------------------------------
module rswf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        forwarded,
  input logic        out_kind,
  input logic [8:0]  out_sampler,
  input logic [31:0] out_value,
  input logic        index_error
);
  import rswf_pkg::*;

  // table clear runs right after reset, so no beat can enter
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input not stalled after reset");

  // an out-of-range write is never passed on
  a_err_not_fwd: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> !forwarded)
    else $error("index error beat marked forwarded");

  // render beats carry no sampler number
  a_render_api: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_RENDER |-> out_sampler == 9'd0)
    else $error("render beat with nonzero sampler number");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(forwarded))
    else $error("stalled result beat changed");

endmodule

bind redundant_state_write_filter rswf_checker u_rswf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .forwarded   (forwarded),
  .out_kind    (out_kind),
  .out_sampler (out_sampler),
  .out_value   (out_value),
  .index_error (index_error)
);
